FILE: design/arpg_pkg.sv
// Package for the axis ring point generator.
// Holds datapath opcodes, command and status structs, config layout and register indexes.
// No dependencies.
package arpg_pkg;

  typedef enum logic [4:0] {
    OP_NONE      = 5'd0,
    OP_LOAD      = 5'd1,
    OP_MUL_CTR   = 5'd2,
    OP_SET_CTR   = 5'd3,
    OP_MUL_M     = 5'd4,
    OP_SET_M     = 5'd5,
    OP_VEC_W     = 5'd6,
    OP_MUL_T     = 5'd7,
    OP_ACC_T     = 5'd8,
    OP_VEC_F     = 5'd9,
    OP_MAG       = 5'd10,
    OP_SHR       = 5'd11,
    OP_SHL       = 5'd12,
    OP_SQ        = 5'd13,
    OP_SUM       = 5'd14,
    OP_SQRT_INIT = 5'd15,
    OP_SQRT_STEP = 5'd16,
    OP_MULQ      = 5'd17,
    OP_DIV_INIT  = 5'd18,
    OP_DIV_STEP  = 5'd19,
    OP_DIV_END   = 5'd20,
    OP_ZERO_OUT  = 5'd21,
    OP_PT_CTR    = 5'd22,
    OP_PT_FIRST  = 5'd23,
    OP_PT_NEXT   = 5'd24
  } op_e;

  typedef enum logic [2:0] {
    REG_START_X  = 3'd0,
    REG_START_Y  = 3'd1,
    REG_START_Z  = 3'd2,
    REG_END_X    = 3'd3,
    REG_END_Y    = 3'd4,
    REG_END_Z    = 3'd5,
    REG_PPR      = 3'd6,
    REG_TAN_STEP = 3'd7
  } reg_idx_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] sel;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic hi;
    logic lo;
    logic special;
    logic degen;
  } stat_t;

  typedef struct packed {
    logic [2:0][23:0] start;
    logic [2:0][23:0] stop;
    logic [6:0]       ppr;
    logic [23:0]      tan_step;
  } cfg_t;

  localparam int unsigned CFG_W  = 24;
  localparam int unsigned FRAC_W = 17;
  localparam int unsigned RAD_W  = 23;

endpackage

FILE: design/arpg_dp.sv
// Datapath of the axis ring point generator: operand registers, one shared multiplier,
// normalizing shifter, bit-serial square root and restoring divider.
// Depends on arpg_pkg.
module arpg_dp #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                  clk_i,
  input  arpg_pkg::cmd_t                        cmd_i,
  input  arpg_pkg::cfg_t                        cfg_i,
  input  logic [arpg_pkg::FRAC_W-1:0]           frac_i,
  input  logic [arpg_pkg::RAD_W-1:0]            radius_i,
  input  logic                                  apex_i,
  output arpg_pkg::stat_t                       stat_o,
  output logic [2:0][COORD_WIDTH-1:0]           pt_o
);
  import arpg_pkg::*;

  localparam logic signed [63:0] SatHi = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] SatLo = -(64'sd1 <<< (COORD_WIDTH - 1));

  function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > SatHi) r = SatHi;
    else if (v < SatLo) r = SatLo;
    return r[COORD_WIDTH-1:0];
  endfunction

  logic signed [23:0]          start_q [3];
  logic signed [24:0]          axis_q  [3];
  logic signed [24:0]          axis_c  [3];
  logic signed [COORD_WIDTH-1:0] center_q [3];
  logic signed [COORD_WIDTH-1:0] prev_q   [3];
  logic signed [COORD_WIDTH:0]   d_c      [3];
  logic signed [63:0]          v_q   [3];
  logic [63:0]                 mag_q [3];
  logic signed [34:0]          out_q [3];
  logic [FRAC_W-1:0]           frac_q;
  logic [RAD_W-1:0]            r_q;
  logic                        apex_q;
  logic                        degen_q;
  logic [31:0]                 m_q;
  logic [31:0]                 len_q;
  logic signed [33:0]          mul_a;
  logic signed [33:0]          mul_b;
  logic signed [67:0]          prod_c;
  logic signed [67:0]          prod_q;
  logic [63:0]                 sum_q;
  logic [63:0]                 x_q;
  logic [63:0]                 res_q;
  logic [63:0]                 bit_q;
  logic [63:0]                 sq_t;
  logic [63:0]                 num_c;
  logic [32:0]                 rem_q;
  logic [63:0]                 nsh_q;
  logic [32:0]                 den_q;
  logic [32:0]                 q_q;
  logic [33:0]                 rr;
  logic                        ge;
  logic [1:0]                  s;

  assign s = cmd_i.sel[1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      axis_c[i] = 25'($signed(cfg_i.stop[i])) - 25'($signed(cfg_i.start[i]));
      d_c[i] = (COORD_WIDTH+1)'(prev_q[i]) - (COORD_WIDTH+1)'(center_q[i]);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_CTR: begin
        mul_a = 34'(frac_q);
        mul_b = 34'(axis_q[s]);
      end
      OP_MUL_M: begin
        mul_a = 34'(cfg_i.tan_step);
        mul_b = 34'(r_q);
      end
      OP_MUL_T: begin
        case (cmd_i.sel)
          3'd0: begin mul_a = 34'(axis_q[1]); mul_b = 34'(d_c[2]); end
          3'd1: begin mul_a = 34'(d_c[1]); mul_b = 34'(axis_q[2]); end
          3'd2: begin mul_a = 34'(d_c[0]); mul_b = 34'(axis_q[2]); end
          3'd3: begin mul_a = 34'(axis_q[0]); mul_b = 34'(d_c[2]); end
          3'd4: begin mul_a = 34'(axis_q[0]); mul_b = 34'(d_c[1]); end
          default: begin mul_a = 34'(d_c[0]); mul_b = 34'(axis_q[1]); end
        endcase
      end
      OP_SQ: begin
        mul_a = 34'(mag_q[s][29:0]);
        mul_b = 34'(mag_q[s][29:0]);
      end
      OP_MULQ: begin
        mul_a = 34'(mag_q[s][29:0]);
        mul_b = 34'(len_q);
      end
      default: ;
    endcase
    prod_c = mul_a * mul_b;
  end

  assign sq_t  = res_q + bit_q;
  assign num_c = {prod_q[62:0], 1'b0} + res_q;
  assign rr    = {rem_q, nsh_q[63]};
  assign ge    = rr >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_MUL_CTR, OP_MUL_M, OP_MUL_T, OP_SQ, OP_MULQ: prod_q <= prod_c;
      default: ;
    endcase
    case (cmd_i.op)
      OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          start_q[i] <= $signed(cfg_i.start[i]);
          axis_q[i]  <= axis_c[i];
        end
        frac_q  <= frac_i;
        r_q     <= radius_i;
        apex_q  <= apex_i;
        degen_q <= (axis_c[0] == '0) && (axis_c[1] == '0);
      end
      OP_SET_CTR: center_q[s] <= sat(64'(start_q[s]) + ((64'(prod_q) + 64'sd32768) >>> 16));
      OP_SET_M: m_q <= 32'((prod_q[47:0] + 48'd32768) >> 16);
      OP_VEC_W: begin
        v_q[0] <= -64'(axis_q[1]);
        v_q[1] <= 64'(axis_q[0]);
        v_q[2] <= '0;
        len_q  <= 32'(r_q);
      end
      OP_ACC_T: begin
        if (!cmd_i.sel[0]) v_q[cmd_i.sel[2:1]] <= 64'(prod_q);
        else v_q[cmd_i.sel[2:1]] <= v_q[cmd_i.sel[2:1]] - 64'(prod_q);
        if (cmd_i.sel == 3'd0) len_q <= m_q;
      end
      OP_VEC_F: begin
        for (int i = 0; i < 3; i++) begin
          v_q[i] <= 64'(prev_q[i]) + 64'(out_q[i]) - 64'(center_q[i]);
        end
        len_q <= 32'(r_q);
      end
      OP_MAG: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= v_q[i][63] ? 64'(-v_q[i]) : 64'(v_q[i]);
        end
      end
      OP_SHR: for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
      OP_SHL: for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
      OP_SUM: sum_q <= (s == 2'd0) ? prod_q[63:0] : sum_q + prod_q[63:0];
      OP_SQRT_INIT: begin
        x_q   <= sum_q;
        res_q <= '0;
        bit_q <= 64'd1 << 62;
      end
      OP_SQRT_STEP: begin
        if (x_q >= sq_t) begin
          x_q   <= x_q - sq_t;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_DIV_INIT: begin
        rem_q <= {2'b00, num_c[63:33]};
        nsh_q <= {num_c[32:0], 31'd0};
        den_q <= {res_q[31:0], 1'b0};
        q_q   <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= ge ? 33'(rr - {1'b0, den_q}) : rr[32:0];
        q_q   <= {q_q[31:0], ge};
        nsh_q <= nsh_q << 1;
      end
      OP_DIV_END: out_q[s] <= v_q[s][63] ? -35'(q_q) : 35'(q_q);
      OP_ZERO_OUT: for (int i = 0; i < 3; i++) out_q[i] <= '0;
      OP_PT_CTR: for (int i = 0; i < 3; i++) prev_q[i] <= center_q[i];
      OP_PT_FIRST: begin
        for (int i = 0; i < 3; i++) prev_q[i] <= sat(64'(center_q[i]) - 64'(out_q[i]));
      end
      OP_PT_NEXT: begin
        for (int i = 0; i < 3; i++) prev_q[i] <= sat(64'(center_q[i]) + 64'(out_q[i]));
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.zero    = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);
    stat_o.hi      = (|mag_q[0][63:30]) || (|mag_q[1][63:30]) || (|mag_q[2][63:30]);
    stat_o.lo      = !((|mag_q[0][63:29]) || (|mag_q[1][63:29]) || (|mag_q[2][63:29]));
    stat_o.special = apex_q || degen_q;
    stat_o.degen   = degen_q;
    for (int i = 0; i < 3; i++) pt_o[i] = prev_q[i];
  end

endmodule

FILE: design/arpg_ctrl.sv
// Sequencer of the axis ring point generator: one-hot state machine that issues
// datapath commands per point and counts points and unit iterations.
// Depends on arpg_pkg.
module arpg_ctrl #(
  parameter int MAX_POINTS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [6:0]      ppr_i,
  input  arpg_pkg::stat_t stat_i,
  input  logic            out_ready_i,
  output arpg_pkg::cmd_t  cmd_o,
  output logic            emit_o,
  output logic            last_o
);
  import arpg_pkg::*;

  localparam int KW = $clog2(MAX_POINTS);

  typedef enum logic [20:0] {
    ST_IDLE      = 21'h000001,
    ST_CTR_MUL   = 21'h000002,
    ST_CTR_SET   = 21'h000004,
    ST_M_MUL     = 21'h000008,
    ST_M_SET     = 21'h000010,
    ST_PT_SEL    = 21'h000020,
    ST_T_MUL     = 21'h000040,
    ST_T_ACC     = 21'h000080,
    ST_MAG       = 21'h000100,
    ST_NORM      = 21'h000200,
    ST_SQ_MUL    = 21'h000400,
    ST_SQ_SUM    = 21'h000800,
    ST_SQRT_INIT = 21'h001000,
    ST_SQRT      = 21'h002000,
    ST_Q_MUL     = 21'h004000,
    ST_DIV_INIT  = 21'h008000,
    ST_DIV       = 21'h010000,
    ST_DIV_END   = 21'h020000,
    ST_VEC_F     = 21'h040000,
    ST_PT_SET    = 21'h080000,
    ST_EMIT      = 21'h100000
  } state_e;

  typedef enum logic [1:0] {
    PH_W = 2'd0,
    PH_T = 2'd1,
    PH_F = 2'd2
  } phase_e;

  state_e          state_q, state_d, done_st;
  phase_e          ph_q, ph_d;
  logic [1:0]      idx_q, idx_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [KW-1:0]   k_q, k_d;
  logic [KW-1:0]   nlast_q, nlast_d;
  logic [6:0]      np_c;

  always_comb begin
    np_c = ppr_i;
    if (ppr_i < 7'd5) np_c = 7'd5;
    else if (ppr_i > 7'(MAX_POINTS)) np_c = 7'(MAX_POINTS);
  end

  assign done_st    = (ph_q == PH_T) ? ST_VEC_F : ST_PT_SET;
  assign in_ready_o = (state_q == ST_IDLE);
  assign last_o     = (k_q == nlast_q);

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    nlast_d = nlast_q;
    cmd_o   = '{op: OP_NONE, sel: 3'd0};
    emit_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          nlast_d  = KW'(np_c - 7'd1);
          k_d      = '0;
          idx_d    = '0;
          state_d  = ST_CTR_MUL;
        end
      end
      ST_CTR_MUL: begin
        cmd_o   = '{op: OP_MUL_CTR, sel: 3'(idx_q)};
        state_d = ST_CTR_SET;
      end
      ST_CTR_SET: begin
        cmd_o = '{op: OP_SET_CTR, sel: 3'(idx_q)};
        if (idx_q == 2'd2) begin
          idx_d   = '0;
          state_d = ST_M_MUL;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_CTR_MUL;
        end
      end
      ST_M_MUL: begin
        cmd_o.op = OP_MUL_M;
        state_d  = ST_M_SET;
      end
      ST_M_SET: begin
        cmd_o.op = OP_SET_M;
        state_d  = ST_PT_SEL;
      end
      ST_PT_SEL: begin
        if (stat_i.special) begin
          state_d = ST_PT_SET;
        end else if (k_q == '0) begin
          cmd_o.op = OP_VEC_W;
          ph_d     = PH_W;
          state_d  = ST_MAG;
        end else begin
          ph_d    = PH_T;
          cnt_d   = '0;
          state_d = ST_T_MUL;
        end
      end
      ST_T_MUL: begin
        cmd_o   = '{op: OP_MUL_T, sel: cnt_q[2:0]};
        state_d = ST_T_ACC;
      end
      ST_T_ACC: begin
        cmd_o = '{op: OP_ACC_T, sel: cnt_q[2:0]};
        if (cnt_q == 6'd5) begin
          state_d = ST_MAG;
        end else begin
          cnt_d   = cnt_q + 6'd1;
          state_d = ST_T_MUL;
        end
      end
      ST_MAG: begin
        cmd_o.op = OP_MAG;
        state_d  = ST_NORM;
      end
      ST_NORM: begin
        if (stat_i.zero) begin
          cmd_o.op = OP_ZERO_OUT;
          state_d  = done_st;
        end else if (stat_i.hi) begin
          cmd_o.op = OP_SHR;
        end else if (stat_i.lo) begin
          cmd_o.op = OP_SHL;
        end else begin
          idx_d   = '0;
          state_d = ST_SQ_MUL;
        end
      end
      ST_SQ_MUL: begin
        cmd_o   = '{op: OP_SQ, sel: 3'(idx_q)};
        state_d = ST_SQ_SUM;
      end
      ST_SQ_SUM: begin
        cmd_o = '{op: OP_SUM, sel: 3'(idx_q)};
        if (idx_q == 2'd2) begin
          idx_d   = '0;
          state_d = ST_SQRT_INIT;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_SQ_MUL;
        end
      end
      ST_SQRT_INIT: begin
        cmd_o.op = OP_SQRT_INIT;
        cnt_d    = '0;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        if (cnt_q == 6'd31) begin
          state_d = ST_Q_MUL;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_Q_MUL: begin
        cmd_o   = '{op: OP_MULQ, sel: 3'(idx_q)};
        state_d = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd_o.op = OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (cnt_q == 6'd32) begin
          state_d = ST_DIV_END;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_DIV_END: begin
        cmd_o = '{op: OP_DIV_END, sel: 3'(idx_q)};
        if (idx_q == 2'd2) begin
          idx_d   = '0;
          state_d = done_st;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_Q_MUL;
        end
      end
      ST_VEC_F: begin
        cmd_o.op = OP_VEC_F;
        ph_d     = PH_F;
        state_d  = ST_MAG;
      end
      ST_PT_SET: begin
        if (stat_i.special) cmd_o.op = OP_PT_CTR;
        else if (ph_q == PH_W) cmd_o.op = OP_PT_FIRST;
        else cmd_o.op = OP_PT_NEXT;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          emit_o = 1'b1;
          if (k_q == nlast_q) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + KW'(1);
            state_d = ST_PT_SEL;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= PH_W;
      idx_q   <= '0;
      cnt_q   <= '0;
      k_q     <= '0;
      nlast_q <= '0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      nlast_q <= nlast_d;
    end
  end

endmodule

FILE: design/axis_ring_point_generator.sv
// Top level of the axis ring point generator: config registers, stream ports, output register.
// Instantiates arpg_ctrl and arpg_dp; depends on arpg_pkg.
//
//  channel   | dir | beat contents
//  s_axis    | in  | tdata: fraction, ring_radius; tuser: is_apex
//  m_axis    | out | tdata: point_x, point_y, point_z; tlast: last_point; tuser: degenerate
//  cfg       | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i (one register per write)
//
// One input beat gives N output beats, N = points_per_ring clamped to 5..MAX_POINTS.
// Apex or degenerate rings give the ring center as every point. Otherwise the first point scales
// one vector and each later point two, each after normalizing shifts of its magnitudes;
// each vector scaling runs a 32-step square root and three 33-step divisions on the shared
// multiplier. A new input beat is taken only after the last point of the ring has gone to
// the output register. A stalled output holds the sequencer in its emit state. Reset needs
// no sweep.
module axis_ring_point_generator #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [39:0]                 s_axis_tdata_i,  // fraction[16:0], ring_radius[39:17]
  input  logic                        s_axis_tuser_i,  // is_apex
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,  // point_x, point_y, point_z
  output logic                        m_axis_tlast_o,
  output logic                        m_axis_tuser_o,  // degenerate
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [arpg_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import arpg_pkg::*;

  localparam int OutW = ((3 * COORD_WIDTH + 7) / 8) * 8;

  cfg_t                        cfg_q;
  cmd_t                        cmd;
  stat_t                       stat;
  logic [2:0][COORD_WIDTH-1:0] pt;
  logic                        emit;
  logic                        last;
  logic                        out_ready;
  logic                        m_valid_q, m_valid_d;
  logic [3*COORD_WIDTH-1:0]    m_data_q;
  logic                        m_last_q;
  logic                        m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start    <= '0;
      cfg_q.stop     <= {24'd0, 24'd0, 24'd65536};
      cfg_q.ppr      <= 7'd24;
      cfg_q.tan_step <= 24'd17560;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_START_X:  cfg_q.start[0] <= cfg_wdata_i;
        REG_START_Y:  cfg_q.start[1] <= cfg_wdata_i;
        REG_START_Z:  cfg_q.start[2] <= cfg_wdata_i;
        REG_END_X:    cfg_q.stop[0]  <= cfg_wdata_i;
        REG_END_Y:    cfg_q.stop[1]  <= cfg_wdata_i;
        REG_END_Z:    cfg_q.stop[2]  <= cfg_wdata_i;
        REG_PPR:      cfg_q.ppr      <= cfg_wdata_i[6:0];
        REG_TAN_STEP: cfg_q.tan_step <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign out_ready = !m_valid_q || m_axis_tready_i;

  arpg_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .ppr_i      (cfg_q.ppr),
    .stat_i     (stat),
    .out_ready_i(out_ready),
    .cmd_o      (cmd),
    .emit_o     (emit),
    .last_o     (last)
  );

  arpg_dp #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_dp (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .cfg_i   (cfg_q),
    .frac_i  (s_axis_tdata_i[16:0]),
    .radius_i(s_axis_tdata_i[39:17]),
    .apex_i  (s_axis_tuser_i),
    .stat_o  (stat),
    .pt_o    (pt)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    if (emit) m_valid_d = 1'b1;
    else if (m_axis_tready_i) m_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_data_q <= {pt[2], pt[1], pt[0]};
      m_last_q <= last;
      m_user_q <= stat.degen;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OutW'(m_data_q);
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

FILE: test/tb_top.sv
// Testbench for axis_ring_point_generator: streams ring requests, predicts every ring point
// and checks each output beat field by field. Depends on arpg_pkg and the RTL only.
module tb_top;
  import arpg_pkg::*;

  typedef struct {
    logic [16:0] frac;
    logic [22:0] rad;
    logic        apex;
  } ring_req_t;

  typedef struct {
    logic signed [23:0] x, y, z;
    logic               last, degen;
  } ring_point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;  // fraction[16:0], ring_radius[39:17]
  logic s_axis_tuser_i = 1'b0;       // is_apex
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;       // point_x[23:0], point_y[47:24], point_z[71:48]
  logic m_axis_tlast_o;
  logic m_axis_tuser_o;              // degenerate
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  axis_ring_point_generator u_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic signed [23:0] cfg_start [3];
  logic signed [23:0] cfg_end [3];
  logic [6:0]         cfg_ppr;
  logic [23:0]        cfg_tan;
  longint             ring_ctr [3];
  longint             prev_pt [3];

  ring_req_t   pending_reqs [$];
  ring_point_t expected_pts [$];
  int          err_cnt = 0;
  bit          in_taken = 0;

  function automatic longint sat24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void scale_vec(input longint v [3], input longint unsigned len,
                                    output longint o [3]);
    longint unsigned mag [3];
    longint unsigned mx, sum, n, q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? -v[i] : v[i];
      if (mag[i] > mx) mx = mag[i];
      o[i] = 0;
    end
    if (mx == 0) return;
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    n = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (2 * mag[i] * len + n) / (2 * n);
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic void predict_ring(ring_req_t rq);
    longint st [3], ax [3], w [3], u [3], d [3], t [3], sv [3], f [3], g [3], p [3];
    longint unsigned step_len;
    int np;
    bit degen;
    ring_point_t rp;
    for (int i = 0; i < 3; i++) begin
      st[i] = cfg_start[i];
      ax[i] = longint'(cfg_end[i]) - st[i];
      ring_ctr[i] = sat24(st[i] + ((longint'(rq.frac) * ax[i] + 32768) >>> 16));
    end
    np = cfg_ppr < 5 ? 5 : (cfg_ppr > 64 ? 64 : int'(cfg_ppr));
    degen = ax[0] == 0 && ax[1] == 0;
    step_len = (longint'(cfg_tan) * longint'(rq.rad) + 32768) >> 16;
    for (int k = 0; k < np; k++) begin
      if (rq.apex || degen) begin
        for (int i = 0; i < 3; i++) p[i] = ring_ctr[i];
      end else if (k == 0) begin
        w[0] = -ax[1];
        w[1] = ax[0];
        w[2] = 0;
        scale_vec(w, longint'(rq.rad), u);
        for (int i = 0; i < 3; i++) p[i] = sat24(ring_ctr[i] - u[i]);
      end else begin
        for (int i = 0; i < 3; i++) d[i] = prev_pt[i] - ring_ctr[i];
        t[0] = ax[1] * d[2] - d[1] * ax[2];
        t[1] = -(ax[0] * d[2] - d[0] * ax[2]);
        t[2] = ax[0] * d[1] - d[0] * ax[1];
        scale_vec(t, step_len, sv);
        for (int i = 0; i < 3; i++) f[i] = prev_pt[i] + sv[i] - ring_ctr[i];
        scale_vec(f, longint'(rq.rad), g);
        for (int i = 0; i < 3; i++) p[i] = sat24(ring_ctr[i] + g[i]);
      end
      for (int i = 0; i < 3; i++) prev_pt[i] = p[i];
      rp.x = p[0][23:0];
      rp.y = p[1][23:0];
      rp.z = p[2][23:0];
      rp.last = k == np - 1;
      rp.degen = degen;
      expected_pts.push_back(rp);
    end
  endfunction

  task automatic report_err(string what, longint exp_v, longint act_v);
    err_cnt++;
    $display("%0t: %s mismatch: expected %0d actual %0d", $time, what, exp_v, act_v);
  endtask

  // predict on accepted requests, check accepted points
  always @(posedge clk_i) begin
    ring_point_t ep;
    logic signed [23:0] ax, ay, az;
    in_taken = s_axis_tvalid_i && s_axis_tready_o;
    if (in_taken) predict_ring(pending_reqs[0]);
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      ax = m_axis_tdata_o[23:0];
      ay = m_axis_tdata_o[47:24];
      az = m_axis_tdata_o[71:48];
      if (expected_pts.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected beat x=%0d y=%0d z=%0d", $time, ax, ay, az);
      end else begin
        ep = expected_pts.pop_front();
        if (ax !== ep.x) report_err("point_x", ep.x, ax);
        if (ay !== ep.y) report_err("point_y", ep.y, ay);
        if (az !== ep.z) report_err("point_z", ep.z, az);
        if (m_axis_tlast_o !== ep.last) report_err("last_point", ep.last, m_axis_tlast_o);
        if (m_axis_tuser_o !== ep.degen) report_err("degenerate", ep.degen, m_axis_tuser_o);
      end
    end
  end

  int burst_left = 0;
  int gap_left = 0;

  // request driver: bursts with random gaps
  always @(negedge clk_i) begin
    bit nv;
    nv = s_axis_tvalid_i;
    if (rst_ni) begin
      if (s_axis_tvalid_i && in_taken) begin
        void'(pending_reqs.pop_front());
        nv = 0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          nv = 1;
          s_axis_tdata_i <= {pending_reqs[0].rad, pending_reqs[0].frac};
          s_axis_tuser_i <= pending_reqs[0].apex;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 900)
                                                   : $urandom_range(0, 3);
          end
          burst_left--;
        end
      end
    end
    s_axis_tvalid_i <= nv;
  end

  int ready_hold = 0;

  // receiver stall pattern
  always @(negedge clk_i) begin
    int mode;
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
        m_axis_tready_i <= 1'b1;
        ready_hold = $urandom_range(20, 300);
      end else if (mode < 8) begin
        m_axis_tready_i <= 1'($urandom_range(0, 1));
        ready_hold = $urandom_range(0, 3);
      end else begin
        m_axis_tready_i <= 1'b0;
        ready_hold = $urandom_range(0, 40);
      end
    end
  end

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_pts.size() != 0 || s_axis_tvalid_i)
      @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_cfg(reg_idx_e idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_START_X, REG_START_Y, REG_START_Z: cfg_start[int'(idx)] = val;
      REG_END_X, REG_END_Y, REG_END_Z: cfg_end[int'(idx) - 3] = val;
      REG_PPR: cfg_ppr = val[6:0];
      default: cfg_tan = val;
    endcase
  endtask

  task automatic set_axis(logic [23:0] sx, sy, sz, ex, ey, ez, logic [6:0] ppr,
                          logic [23:0] tan);
    wait_idle();
    write_cfg(REG_START_X, sx);
    write_cfg(REG_START_Y, sy);
    write_cfg(REG_START_Z, sz);
    write_cfg(REG_END_X, ex);
    write_cfg(REG_END_Y, ey);
    write_cfg(REG_END_Z, ez);
    write_cfg(REG_PPR, {17'd0, ppr});
    write_cfg(REG_TAN_STEP, tan);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_req(logic [16:0] frac, logic [22:0] rad, logic apex);
    ring_req_t rq;
    rq.frac = frac;
    rq.rad = rad;
    rq.apex = apex;
    pending_reqs.push_back(rq);
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7fffff;
      default: return 24'($signed($urandom_range(0, (1 << $urandom_range(8, 23)) - 1))
                          - (1 << 22) * $urandom_range(0, 1));
    endcase
  endfunction

  task automatic add_random_req();
    logic [16:0] frac;
    logic [22:0] rad;
    frac = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(65537, 131071))
                                       : 17'($urandom_range(0, 65536));
    rad = 23'($urandom_range(0, (1 << $urandom_range(1, 23)) - 1));
    add_req(frac, rad, $urandom_range(0, 4) == 0);
  endtask

  initial begin
    logic [6:0] ppr;
    cfg_start = '{default: '0};
    cfg_end = '{24'sd65536, 24'sd0, 24'sd0};
    cfg_ppr = 7'd24;
    cfg_tan = 24'd17560;
    ring_ctr = '{default: 0};
    prev_pt = '{default: 0};
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: axis along x, 24 points
    add_req(17'd0, 23'd65536, 1'b0);
    add_req(17'd65536, 23'd8388607, 1'b0);
    add_req(17'd131071, 23'd0, 1'b0);
    add_req(17'd32768, 23'd65536, 1'b1);
    add_req(17'd21845, 23'd1, 1'b0);

    // zero length axis at the extremes, largest ring
    set_axis(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
             7'd64, 24'd6454);
    add_req(17'd65536, 23'd8388607, 1'b0);
    add_req(17'd131071, 23'd12345, 1'b1);

    // axis parallel to z, point count above range
    set_axis(24'd100, 24'hfffff0, 24'h800000, 24'd100, 24'hfffff0, 24'h7fffff,
             7'd127, 24'hffffff);
    add_req(17'd131071, 23'd8388607, 1'b0);
    add_req(17'd0, 23'd400000, 1'b1);

    // opposite corners: saturation, point count below range, max step
    set_axis(24'h800000, 24'h7fffff, 24'd0, 24'h7fffff, 24'h800000, 24'h7fffff,
             7'd0, 24'hffffff);
    add_req(17'd65536, 23'd8388607, 1'b0);
    add_req(17'd131071, 23'd8388607, 1'b0);
    add_req(17'd0, 23'd8388607, 1'b1);
    add_req(17'd40000, 23'd300000, 1'b0);

    // no step, tilted axis
    set_axis(24'd0, 24'd0, 24'd0, 24'd65536, 24'd65536, 24'd65536, 7'd5, 24'd0);
    add_req(17'd32768, 23'd131072, 1'b0);
    add_req(17'd65536, 23'd0, 1'b0);

    for (int ph = 0; ph < 9; ph++) begin
      ppr = (ph == 8) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(5, 8));
      set_axis(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
               rand_coord(), ppr,
               ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(30000, 210000)));
      for (int j = 0; j < (ph == 8 ? 8 : 35); j++) begin
        add_random_req();
        // hold the sender once until every point is back
        if (ph == 3 && j == 17) wait_idle();
      end
    end

    wait_idle();
    repeat (500) @(negedge clk_i);
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
